[rtl/fwbc_pkg.sv]
// Shared types, codes and helpers for the write-back block cache tag controller.
package fwbc_pkg;

   localparam int ENTRIES_DEFAULT     = 16;
   localparam int BLOCK_BYTES_DEFAULT = 512;
   localparam int HEAD_BLOCKS         = 1 + 1;
   localparam int BB_W                = 13;
   localparam int OFS_W               = 34;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_MARK  = 2'd1;
   localparam logic [1:0] FUNC_SYNC  = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   localparam logic [1:0] KIND_HIT  = 2'd0;
   localparam logic [1:0] KIND_WB   = 2'd1;
   localparam logic [1:0] KIND_FILL = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] file_id;
      logic [23:0] block_number;
      logic [3:0]  slot;
   } req_item_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       slot_out;
      logic [15:0]      file_out;
      logic [23:0]      block_out;
      logic [OFS_W-1:0] byte_offset;
      logic             last;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] file;
      logic [23:0] block;
   } tag_type;

   // Device byte offset of a block, wrapped to the offset width.
   function automatic logic [OFS_W-1:0] offset_of(input logic [23:0] blk,
                                                  input logic [BB_W-1:0] bb);
      logic [25:0] b2;
      logic [38:0] prod;
      b2   = 26'(blk) + 26'(HEAD_BLOCKS);
      prod = 39'(b2) * 39'(bb);
      return prod[OFS_W-1:0];
   endfunction

endpackage

[rtl/fifo_writeback_block_cache_tags.sv]
// An allocate hit returns its item when the scan reaches the matching slot; a miss
//   emits a write-back item first when the victim is dirty, then the fill item;
//   sync emits a write-back per dirty slot of its file during the scan, then done.
// Throughput: one item at a time in the back end, paced by the single tag RAM read port
//   (one tag per cycle while scanning); mark-dirty needs no scan.
// A two-item request queue lets new items in while the back end works; busy = queue full.
// Reset (synchronous) empties the queue, clears occupancy, oldest pointer and dirty marks.
module fifo_writeback_block_cache_tags import fwbc_pkg::*; #(
   parameter int ENTRIES     = ENTRIES_DEFAULT,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   logic         q_valid;
   req_item_type q_head;
   logic         q_pop;

   // front: take items, drop unknown request kinds, hold the rest in order
   fwbc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   // back: scan tags, pick victims, emit write-back, fill, hit and done items
   fwbc_back #(
      .ENTRIES     (ENTRIES),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

[rtl/fwbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fwbc_ram import fwbc_pkg::*; #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fwbc_front.sv]
// Front end: accept requests, drop unknown kinds, queue the rest in order.
module fwbc_front import fwbc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         q_valid,
   output req_item_type q_head,
   input  logic         q_pop
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   req_item_type   q_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           push;
   logic           pop;

   assign busy    = (count_ff == CW'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = q_ff[rd_ptr_ff];
   assign push    = start && !busy && (req_item.func != FUNC_NONE);
   assign pop     = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

[rtl/fwbc_back.sv]
// Back end: tag scan, victim choice, write-back and fill sequencing, sync sweep.
module fwbc_back import fwbc_pkg::*; #(
   parameter int ENTRIES     = ENTRIES_DEFAULT,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  req_item_type q_head,
   output logic         q_pop,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW  = $clog2(ENTRIES + 1);
   localparam int CMW = (OW > 4) ? OW : 4;
   localparam logic [BB_W-1:0] BB = BB_W'(BLOCK_BYTES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ASCAN = 3'd1;
   localparam logic [2:0] S_VICT  = 3'd2;
   localparam logic [2:0] S_VWB   = 3'd3;
   localparam logic [2:0] S_FILL  = 3'd4;
   localparam logic [2:0] S_SSCAN = 3'd5;
   localparam logic [2:0] S_SDONE = 3'd6;

   logic [2:0]         state_ff, state_in;
   req_item_type       cmd_ff, cmd_in;
   logic [SW-1:0]      pos_ff, pos_in;
   logic [OW-1:0]      cnt_ff, cnt_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_last_ff, rd_last_in;
   logic [SW-1:0]      rd_slot_ff, rd_slot_in;
   logic [SW-1:0]      victim_ff, victim_in;
   logic [OW-1:0]      occ_ff, occ_in;
   logic [SW-1:0]      oldest_ff, oldest_in;
   logic [ENTRIES-1:0] dirty_ff, dirty_in;
   logic               rsp_vld_ff, rsp_vld_in;
   rsp_item_type       rsp_ff, rsp_in;

   logic               ram_wr_en;
   logic [SW-1:0]      ram_wr_addr;
   tag_type            ram_wr_data;
   logic               ram_rd_en;
   logic [SW-1:0]      ram_rd_addr;
   tag_type            ram_rd_data;
   logic [SW-1:0]      mark_idx;

   fwbc_ram #(
      .WIDTH ($bits(tag_type)),
      .DEPTH (ENTRIES)
   ) u_tags (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign mark_idx = SW'(q_head.slot);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      rd_vld_in   = 1'b0;
      rd_last_in  = rd_last_ff;
      rd_slot_in  = rd_slot_ff;
      victim_in   = victim_ff;
      occ_in      = occ_ff;
      oldest_in   = oldest_ff;
      dirty_in    = dirty_ff;
      rsp_vld_in  = 1'b0;
      rsp_in      = rsp_ff;
      q_pop       = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = victim_ff;
      ram_wr_data = '{file: cmd_ff.file_id, block: cmd_ff.block_number};
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_ff;

      // issue one tag read per cycle while scanning
      if ((state_ff == S_ASCAN || state_ff == S_SSCAN) && cnt_ff != occ_ff) begin
         ram_rd_en  = 1'b1;
         rd_vld_in  = 1'b1;
         rd_last_in = (cnt_ff == occ_ff - OW'(1));
         rd_slot_in = pos_ff;
         pos_in     = (pos_ff == SW'(ENTRIES - 1)) ? '0 : pos_ff + SW'(1);
         cnt_in     = cnt_ff + OW'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               cnt_in = '0;
               unique case (q_head.func)
                  FUNC_ALLOC: begin
                     pos_in   = oldest_ff;
                     state_in = (occ_ff == '0) ? S_VICT : S_ASCAN;
                  end
                  FUNC_MARK: begin
                     if (CMW'(q_head.slot) < CMW'(occ_ff)) begin
                        dirty_in[mark_idx] = 1'b1;
                     end
                  end
                  FUNC_SYNC: begin
                     pos_in   = '0;
                     state_in = (occ_ff == '0) ? S_SDONE : S_SSCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ASCAN: begin
            if (rd_vld_ff) begin
               if (ram_rd_data.file == cmd_ff.file_id &&
                   ram_rd_data.block == cmd_ff.block_number) begin
                  rsp_vld_in = 1'b1;
                  rsp_in     = '{kind: KIND_HIT, slot_out: 4'(rd_slot_ff),
                                 file_out: cmd_ff.file_id,
                                 block_out: cmd_ff.block_number,
                                 byte_offset: offset_of(cmd_ff.block_number, BB),
                                 last: 1'b1};
                  rd_vld_in  = 1'b0;
                  state_in   = S_IDLE;
               end else if (rd_last_ff) begin
                  rd_vld_in = 1'b0;
                  state_in  = S_VICT;
               end
            end
         end
         S_VICT: begin
            if (occ_ff < OW'(ENTRIES)) begin
               victim_in = SW'(occ_ff);
               occ_in    = occ_ff + OW'(1);
            end else begin
               victim_in = oldest_ff;
               oldest_in = (oldest_ff == SW'(ENTRIES - 1)) ? '0 : oldest_ff + SW'(1);
            end
            if (dirty_ff[victim_in]) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = victim_in;
               state_in    = S_VWB;
            end else begin
               state_in = S_FILL;
            end
         end
         S_VWB: begin
            rsp_vld_in          = 1'b1;
            rsp_in              = '{kind: KIND_WB, slot_out: 4'(victim_ff),
                                    file_out: ram_rd_data.file,
                                    block_out: ram_rd_data.block,
                                    byte_offset: offset_of(ram_rd_data.block, BB),
                                    last: 1'b0};
            dirty_in[victim_ff] = 1'b0;
            state_in            = S_FILL;
         end
         S_FILL: begin
            ram_wr_en  = 1'b1;
            rsp_vld_in = 1'b1;
            rsp_in     = '{kind: KIND_FILL, slot_out: 4'(victim_ff),
                           file_out: cmd_ff.file_id,
                           block_out: cmd_ff.block_number,
                           byte_offset: offset_of(cmd_ff.block_number, BB),
                           last: 1'b1};
            state_in   = S_IDLE;
         end
         S_SSCAN: begin
            if (rd_vld_ff) begin
               if (ram_rd_data.file == cmd_ff.file_id && dirty_ff[rd_slot_ff]) begin
                  rsp_vld_in           = 1'b1;
                  rsp_in               = '{kind: KIND_WB, slot_out: 4'(rd_slot_ff),
                                           file_out: ram_rd_data.file,
                                           block_out: ram_rd_data.block,
                                           byte_offset: offset_of(ram_rd_data.block, BB),
                                           last: 1'b0};
                  dirty_in[rd_slot_ff] = 1'b0;
               end
               if (rd_last_ff) begin
                  rd_vld_in = 1'b0;
                  state_in  = S_SDONE;
               end
            end
         end
         S_SDONE: begin
            rsp_vld_in = 1'b1;
            rsp_in     = '{kind: KIND_DONE, slot_out: 4'd0, file_out: cmd_ff.file_id,
                           block_out: 24'd0, byte_offset: '0, last: 1'b1};
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_vld_ff  <= 1'b0;
         occ_ff     <= '0;
         oldest_ff  <= '0;
         dirty_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         occ_ff     <= occ_in;
         oldest_ff  <= oldest_in;
         dirty_ff   <= dirty_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      pos_ff     <= pos_in;
      cnt_ff     <= cnt_in;
      rd_last_ff <= rd_last_in;
      rd_slot_ff <= rd_slot_in;
      victim_ff  <= victim_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_item   = rsp_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(ENTRIES))
      else $error("occupancy above slot count");

   a_occ_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> occ_ff >= $past(occ_ff))
      else $error("occupancy decreased");

   a_oldest_full: assert property (@(posedge clock) disable iff (reset)
      oldest_ff != '0 |-> occ_ff == OW'(ENTRIES))
      else $error("oldest pointer moved before cache filled");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.last == (rsp_ff.kind != KIND_WB)))
      else $error("last flag disagrees with result kind");

endmodule

[sim/tb.sv]
// Self-checking testbench for the write-back block cache tag and replacement controller.
module tb;
   import fwbc_pkg::*;

   localparam int unsigned SLOTS       = ENTRIES_DEFAULT;
   localparam int unsigned STALL_LIMIT = 2000;

   // Tag mirror of the cache. Every accepted item updates the mirror and queues the
   // results it should cause. Results are compared in arrival order.
   class cache_tag_scoreboard;
      logic [15:0]  tag_file [SLOTS];
      logic [23:0]  tag_block [SLOTS];
      logic         dirty [SLOTS];
      int unsigned  fill_count;
      logic [3:0]   oldest;
      rsp_item_type pending_results [$];
      int unsigned  errors;

      function new();
         foreach (tag_file[i]) begin
            tag_file[i]  = '0;
            tag_block[i] = '0;
            dirty[i]     = 1'b0;
         end
         fill_count = 0;
         oldest     = '0;
         errors     = 0;
      endfunction

      function logic [OFS_W-1:0] device_offset(logic [23:0] blk);
         return (OFS_W'(blk) + OFS_W'(HEAD_BLOCKS)) * OFS_W'(BLOCK_BYTES_DEFAULT);
      endfunction

      function void queue_result(logic [1:0] kind, logic [3:0] slot, logic [15:0] file,
                                 logic [23:0] blk, logic [OFS_W-1:0] ofs, logic last);
         rsp_item_type r;
         r.kind        = kind;
         r.slot_out    = slot;
         r.file_out    = file;
         r.block_out   = blk;
         r.byte_offset = ofs;
         r.last        = last;
         pending_results.push_back(r);
      endfunction

      function void note_request(req_item_type req);
         logic [3:0] pos;
         logic [3:0] victim;
         bit         hit;
         int unsigned k;
         hit = 1'b0;
         case (req.func)
            FUNC_ALLOC: begin
               // Scan occupied slots in FIFO order, oldest first.
               pos = oldest;
               for (k = 0; k < fill_count && !hit; k++) begin
                  if (tag_file[pos] == req.file_id && tag_block[pos] == req.block_number) begin
                     queue_result(KIND_HIT, pos, req.file_id, req.block_number,
                                  device_offset(req.block_number), 1'b1);
                     hit = 1'b1;
                  end else begin
                     pos = pos + 1'b1;
                  end
               end
               if (!hit) begin
                  if (fill_count < SLOTS) begin
                     victim = fill_count[3:0];
                     fill_count++;
                  end else begin
                     victim = oldest;
                     oldest = oldest + 1'b1;
                  end
                  if (dirty[victim]) begin
                     queue_result(KIND_WB, victim, tag_file[victim], tag_block[victim],
                                  device_offset(tag_block[victim]), 1'b0);
                     dirty[victim] = 1'b0;
                  end
                  tag_file[victim]  = req.file_id;
                  tag_block[victim] = req.block_number;
                  queue_result(KIND_FILL, victim, req.file_id, req.block_number,
                               device_offset(req.block_number), 1'b1);
               end
            end
            FUNC_MARK: begin
               if (req.slot < fill_count) dirty[req.slot] = 1'b1;
            end
            FUNC_SYNC: begin
               for (k = 0; k < fill_count; k++) begin
                  if (tag_file[k] == req.file_id && dirty[k]) begin
                     queue_result(KIND_WB, k[3:0], tag_file[k], tag_block[k],
                                  device_offset(tag_block[k]), 1'b0);
                     dirty[k] = 1'b0;
                  end
               end
               queue_result(KIND_DONE, '0, req.file_id, '0, '0, 1'b1);
            end
            default: begin
            end
         endcase
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: kind %0d slot %0d", got.kind, got.slot_out);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            errors++;
         end
         if (got.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, actual %0d", want.slot_out, got.slot_out);
            errors++;
         end
         if (got.file_out !== want.file_out) begin
            $error("file_out: expected %h, actual %h", want.file_out, got.file_out);
            errors++;
         end
         if (got.block_out !== want.block_out) begin
            $error("block_out: expected %h, actual %h", want.block_out, got.block_out);
            errors++;
         end
         if (got.byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected %h, actual %h", want.byte_offset, got.byte_offset);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   cache_tag_scoreboard sb;
   int unsigned         stall_cycles;
   bit                  no_idle;
   logic [15:0]         file_pool [3];

   fifo_writeback_block_cache_tags dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Check every strobed result; the receiver never stalls, so strobe means accepted.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_item);
   end

   // Watchdog: count cycles in which neither an item nor a result is accepted.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Drive one item: idle for a random gap (none in burst stretches), then hold start
   // until the block takes the item. Keep start high when the next gap is zero.
   task automatic send_request(input req_item_type item);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      sb.note_request(item);
   endtask

   task automatic send_fields(input logic [1:0] func, input logic [15:0] file,
                              input logic [23:0] blk, input logic [3:0] slot);
      req_item_type item;
      item.func         = func;
      item.file_id      = file;
      item.block_number = blk;
      item.slot         = slot;
      send_request(item);
   endtask

   // Hold the sender off until every expected result is back.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
   endtask

   // Mostly allocates over a small tag set so hits, fills and dirty evictions all
   // occur; the rest marks slots, syncs files, and sprinkles wide values and noise.
   function automatic req_item_type random_request();
      req_item_type r;
      int unsigned  pick;
      r.func         = FUNC_ALLOC;
      r.file_id      = file_pool[$urandom_range(0, 2)];
      r.block_number = 24'($urandom_range(0, 9));
      r.slot         = 4'($urandom_range(0, 15));
      pick           = $urandom_range(0, 99);
      if (pick < 45) begin
      end else if (pick < 55) begin
         r.file_id      = 16'($urandom);
         r.block_number = 24'($urandom);
      end else if (pick < 78) begin
         r.func = FUNC_MARK;
      end else if (pick < 93) begin
         r.func = FUNC_SYNC;
      end else if (pick < 96) begin
         r.func    = FUNC_SYNC;
         r.file_id = 16'($urandom);
      end else begin
         r.func         = FUNC_NONE;
         r.file_id      = 16'($urandom);
         r.block_number = 24'($urandom);
      end
      return r;
   endfunction

   initial begin
      int unsigned n;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      no_idle  = 1'b0;
      sb       = new();
      foreach (file_pool[i]) file_pool[i] = 16'($urandom);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty cache, ignored items, field extremes, hits, dirty syncs.
      send_fields(FUNC_SYNC, 16'h0000, 24'h000000, 4'h0);  // sync on empty cache: done only
      send_fields(FUNC_MARK, 16'h0000, 24'h000000, 4'h0);  // mark with nothing held: ignored
      send_fields(FUNC_NONE, 16'hFFFF, 24'hFFFFFF, 4'hF);  // unknown request: ignored
      send_fields(FUNC_ALLOC, 16'hFFFF, 24'hFFFFFF, 4'h0); // largest tag, largest offset
      send_fields(FUNC_ALLOC, 16'h0000, 24'h000000, 4'h0);
      send_fields(FUNC_ALLOC, 16'hFFFF, 24'hFFFFFF, 4'h0); // hit on slot 0
      send_fields(FUNC_ALLOC, 16'h0000, 24'h000000, 4'h0); // hit on slot 1
      send_fields(FUNC_MARK, 16'h0000, 24'h000000, 4'h0);
      send_fields(FUNC_MARK, 16'hFFFF, 24'hFFFFFF, 4'hF);  // mark beyond occupancy: ignored
      send_fields(FUNC_MARK, 16'h0000, 24'h000000, 4'h1);
      send_fields(FUNC_SYNC, 16'h0000, 24'h000000, 4'h0);  // writes back slot 1 only
      send_fields(FUNC_SYNC, 16'hFFFF, 24'h000000, 4'h0);  // writes back slot 0
      send_fields(FUNC_SYNC, 16'hFFFF, 24'h000000, 4'h0);  // nothing dirty left
      send_fields(FUNC_ALLOC, 16'hA5A5, 24'h5A5A5A, 4'h0);
      send_fields(FUNC_MARK, 16'h0000, 24'h000000, 4'h2);
      send_fields(FUNC_ALLOC, 16'h5A5A, 24'hA5A5A5, 4'h0);
      send_fields(FUNC_ALLOC, 16'hA5A5, 24'h5A5A5A, 4'h0); // hit on a dirty slot
      drain_results();

      // Random: stretches with or without idle gaps, chosen at random; drain now and then.
      for (n = 0; n < 320; n++) begin
         if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
         send_request(random_request());
         if (n % 100 == 99) drain_results();
      end

      // Drain, then let the back end settle.
      drain_results();
      repeat (SLOTS + 10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/fwbc_pkg.sv
rtl/fwbc_ram.sv
rtl/fwbc_front.sv
rtl/fwbc_back.sv
rtl/fifo_writeback_block_cache_tags.sv
sim/tb.sv
